### sv/utf8_decoder_with_line_column_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef UTF8_DECODER_WITH_LINE_COLUMN_MACROS_SVH
`define UTF8_DECODER_WITH_LINE_COLUMN_MACROS_SVH

// expr must hold at every clock edge out of reset
`define UTF8LC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante at one edge implies cons at the same edge
`define UTF8LC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante at one edge implies cons at the next edge
`define UTF8LC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/utf8lc_pkg.sv
package utf8lc_pkg;

  localparam int ROW_WIDTH = 20;
  localparam int COL_WIDTH = 16;
  localparam int CP_WIDTH  = 21;
  localparam int BYTE_W    = 8;

  localparam int OUT_FIELDS_W  = CP_WIDTH + ROW_WIDTH + COL_WIDTH + BYTE_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [ROW_WIDTH-1:0] ROW_MAX = '1;
  localparam logic [COL_WIDTH-1:0] COL_MAX = '1;

  localparam logic [BYTE_W-1:0] TAB_WIDTH_RESET = 8'd4;

  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;

  localparam logic [CP_WIDTH-1:0] CP_TAB     = 21'd9;
  localparam logic [CP_WIDTH-1:0] CP_NEWLINE = 21'd10;

  typedef struct packed {
    logic [ROW_WIDTH-1:0] line;
    logic [COL_WIDTH-1:0] col;
    logic [7:0]           phase;
    logic [1:0]           pend;
    logic [CP_WIDTH-1:0]  partial;
    logic [BYTE_W-1:0]    lead;
    logic                 after_cr;
    logic                 emitted;
    logic                 last_nl;
    logic                 halted;
  } state_t;

  typedef struct packed {
    logic [CP_WIDTH-1:0]  cp;
    logic [ROW_WIDTH-1:0] row;
    logic [COL_WIDTH-1:0] col;
    logic                 bad;
    logic [BYTE_W-1:0]    off;
    logic                 last;
  } result_t;

  function automatic state_t clear_state();
    state_t s;
    s          = '0;
    s.line     = ROW_WIDTH'(1);
    s.col      = COL_WIDTH'(1);
    return s;
  endfunction

endpackage

### sv/utf8_decoder_with_line_column.sv
// Channel  Dir  Width  Contents (low bit up)
// in_      in   8      tdata: byte_value; tlast: end_of_input
// out_     out  72     tdata: code_point, row, column, offending_byte, pad;
//                      tuser: bad_utf8; tlast: last_result
// cfg_     in   8      data: tab_width (0 is ignored)
//
// One byte is accepted per cycle while in_tready is high; its results (at most two) land in a
// four-entry result queue on the same edge and leave one per cycle while out_tready is high.
// in_tready is high while the queue has room for two results.
// rst_n is synchronous; tab_width returns to 4, the line/column state to 1/1.
// A stalled output only holds the input off once the queue has fewer than two slots free.
`include "utf8_decoder_with_line_column_macros.svh"

module utf8_decoder_with_line_column (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // byte_value
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // code_point, row, column, offending_byte, zero pad
  output logic [utf8lc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // bad_utf8
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_data
);

  logic [7:0]          tab_width_r;
  utf8lc_pkg::state_t  st_r;
  utf8lc_pkg::state_t  st_nxt;
  utf8lc_pkg::result_t res0;
  utf8lc_pkg::result_t res1;
  logic [1:0]          step_n;

  utf8lc_pkg::result_t mem_r [4];
  logic [1:0]          wr_ptr_r;
  logic [1:0]          rd_ptr_r;
  logic [2:0]          count_r;

  logic                in_acc;
  logic                pop;
  logic [1:0]          push_n;
  utf8lc_pkg::result_t head;

  utf8lc_step u_step (
    .state_i     (st_r),
    .tab_width_i (tab_width_r),
    .byte_i      (in_tdata),
    .eoi_i       (in_tlast),
    .state_nxt_o (st_nxt),
    .res0_o      (res0),
    .res1_o      (res1),
    .count_o     (step_n)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (count_r <= 3'd2);
  assign in_acc    = in_tvalid && in_tready;
  assign push_n    = in_acc ? step_n : 2'd0;
  assign out_tvalid = (count_r != 3'd0);
  assign pop       = out_tvalid && out_tready;
  assign head      = mem_r[rd_ptr_r];

  assign out_tdata = {{utf8lc_pkg::OUT_PAD_W{1'b0}}, head.off, head.col, head.row, head.cp};
  assign out_tuser = head.bad;
  assign out_tlast = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= utf8lc_pkg::TAB_WIDTH_RESET;
      st_r        <= utf8lc_pkg::clear_state();
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_data != 8'd0) begin
        tab_width_r <= cfg_data;
      end
      if (in_acc) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + push_n;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  `UTF8LC_ASSERT_ALWAYS(a_queue_bound, count_r <= 3'd4, "result queue overflow")
  `UTF8LC_ASSERT_IMPLY(a_halt_silent, in_acc && st_r.halted, push_n == 2'd0, "output while halted")
  `UTF8LC_ASSERT_IMPLY(a_err_last, push_n != 2'd0 && res0.bad, res0.last && push_n == 2'd1, "error result not final")
  `UTF8LC_ASSERT_NEXT(a_eoi_clear, in_acc && in_tlast, st_r.line == utf8lc_pkg::ROW_WIDTH'(1) && !st_r.halted && st_r.pend == 2'd0, "state not cleared at end of stream")
  `UTF8LC_ASSERT_ALWAYS(a_row_nonzero, st_r.line != '0 && st_r.col != '0, "row or column zero")

endmodule

### sv/utf8lc_step.sv
module utf8lc_step (
  input  utf8lc_pkg::state_t  state_i,
  input  logic [7:0]          tab_width_i,
  input  logic [7:0]          byte_i,
  input  logic                eoi_i,
  output utf8lc_pkg::state_t  state_nxt_o,
  output utf8lc_pkg::result_t res0_o,
  output utf8lc_pkg::result_t res1_o,
  output logic [1:0]          count_o
);

  function automatic utf8lc_pkg::result_t mk(
    logic [utf8lc_pkg::CP_WIDTH-1:0] cp, utf8lc_pkg::state_t st, logic bad, logic [7:0] off);
    utf8lc_pkg::result_t r;
    r.cp   = cp;
    r.row  = st.line;
    r.col  = st.col;
    r.bad  = bad;
    r.off  = off;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic utf8lc_pkg::state_t nl_update(utf8lc_pkg::state_t st);
    utf8lc_pkg::state_t s;
    s = st;
    if (s.line != utf8lc_pkg::ROW_MAX) begin
      s.line = s.line + utf8lc_pkg::ROW_WIDTH'(1);
    end
    s.col     = utf8lc_pkg::COL_WIDTH'(1);
    s.phase   = '0;
    s.emitted = 1'b1;
    s.last_nl = 1'b1;
    return s;
  endfunction

  function automatic utf8lc_pkg::state_t char_update(utf8lc_pkg::state_t st, logic [7:0] tw);
    utf8lc_pkg::state_t s;
    logic [utf8lc_pkg::COL_WIDTH:0] csum;
    logic [8:0] ph1;
    s    = st;
    csum = {1'b0, s.col} + (utf8lc_pkg::COL_WIDTH+1)'(1);
    s.col = csum[utf8lc_pkg::COL_WIDTH] ? utf8lc_pkg::COL_MAX
                                        : csum[utf8lc_pkg::COL_WIDTH-1:0];
    ph1 = {1'b0, s.phase} + 9'd1;
    s.phase   = (ph1 >= {1'b0, tw}) ? 8'd0 : ph1[7:0];
    s.emitted = 1'b1;
    s.last_nl = 1'b0;
    return s;
  endfunction

  function automatic utf8lc_pkg::state_t tab_update(utf8lc_pkg::state_t st, logic [7:0] tw);
    utf8lc_pkg::state_t s;
    logic [utf8lc_pkg::COL_WIDTH:0] csum;
    logic [7:0] adv;
    s    = st;
    adv  = (s.phase < tw) ? (tw - s.phase) : 8'd1;
    csum = {1'b0, s.col} + (utf8lc_pkg::COL_WIDTH+1)'(adv);
    s.col = csum[utf8lc_pkg::COL_WIDTH] ? utf8lc_pkg::COL_MAX
                                        : csum[utf8lc_pkg::COL_WIDTH-1:0];
    s.phase   = '0;
    s.emitted = 1'b1;
    s.last_nl = 1'b0;
    return s;
  endfunction

  utf8lc_pkg::state_t              s;
  utf8lc_pkg::result_t             r0;
  utf8lc_pkg::result_t             r1;
  logic [1:0]                      n;
  logic                            err;
  logic [7:0]                      eb;
  logic [utf8lc_pkg::CP_WIDTH-1:0] pc;

  always_comb begin
    s   = state_i;
    r0  = '0;
    r1  = '0;
    n   = 2'd0;
    err = 1'b0;
    eb  = '0;
    pc  = '0;
    if (s.halted) begin
      if (eoi_i) begin
        s = utf8lc_pkg::clear_state();
      end
    end else begin
      if (s.pend != 2'd0) begin
        if (byte_i[7:6] == 2'b10) begin
          pc        = {s.partial[utf8lc_pkg::CP_WIDTH-7:0], byte_i[5:0]};
          s.partial = pc;
          s.pend    = s.pend - 2'd1;
          if (s.pend == 2'd0) begin
            if (pc == '0) begin
              err = 1'b1;
              eb  = s.lead;
            end else begin
              r0 = mk(pc, s, 1'b0, 8'd0);
              s  = char_update(s, tab_width_i);
              n  = 2'd1;
            end
          end
        end else begin
          err = 1'b1;
          eb  = s.lead;
        end
      end else if (s.after_cr && byte_i == utf8lc_pkg::BYTE_LF) begin
        s.after_cr = 1'b0;
      end else begin
        s.after_cr = 1'b0;
        if (byte_i == utf8lc_pkg::BYTE_CR) begin
          r0 = mk(utf8lc_pkg::CP_NEWLINE, s, 1'b0, 8'd0);
          s  = nl_update(s);
          s.after_cr = 1'b1;
          n  = 2'd1;
        end else if (byte_i == utf8lc_pkg::BYTE_LF) begin
          r0 = mk(utf8lc_pkg::CP_NEWLINE, s, 1'b0, 8'd0);
          s  = nl_update(s);
          n  = 2'd1;
        end else if (byte_i == utf8lc_pkg::BYTE_TAB) begin
          r0 = mk(utf8lc_pkg::CP_TAB, s, 1'b0, 8'd0);
          s  = tab_update(s, tab_width_i);
          n  = 2'd1;
        end else if (byte_i == utf8lc_pkg::BYTE_NUL) begin
          err = 1'b1;
          eb  = '0;
        end else if (!byte_i[7]) begin
          r0 = mk(utf8lc_pkg::CP_WIDTH'(byte_i), s, 1'b0, 8'd0);
          s  = char_update(s, tab_width_i);
          n  = 2'd1;
        end else begin
          s.lead = byte_i;
          if (byte_i[7:5] == 3'b110) begin
            s.partial = utf8lc_pkg::CP_WIDTH'(byte_i[4:0]);
            s.pend    = 2'd1;
          end else if (byte_i[7:4] == 4'b1110) begin
            s.partial = utf8lc_pkg::CP_WIDTH'(byte_i[3:0]);
            s.pend    = 2'd2;
          end else if (byte_i[7:3] == 5'b11110) begin
            s.partial = utf8lc_pkg::CP_WIDTH'(byte_i[2:0]);
            s.pend    = 2'd3;
          end else begin
            err = 1'b1;
            eb  = byte_i;
          end
        end
      end

      // truncated sequence at end of stream
      if (!err && eoi_i && s.pend != 2'd0) begin
        err = 1'b1;
        eb  = s.lead;
      end

      if (err) begin
        r0      = mk('0, s, 1'b1, eb);
        r0.last = 1'b1;
        n       = 2'd1;
        s.halted = 1'b1;
        if (eoi_i) begin
          s = utf8lc_pkg::clear_state();
        end
      end else if (eoi_i) begin
        if (s.emitted && !s.last_nl) begin
          if (n == 2'd0) begin
            r0 = mk(utf8lc_pkg::CP_NEWLINE, s, 1'b0, 8'd0);
          end else begin
            r1 = mk(utf8lc_pkg::CP_NEWLINE, s, 1'b0, 8'd0);
          end
          s = nl_update(s);
          n = n + 2'd1;
        end
        if (n == 2'd1) begin
          r0.last = 1'b1;
        end
        if (n == 2'd2) begin
          r1.last = 1'b1;
        end
        s = utf8lc_pkg::clear_state();
      end
    end
  end

  assign state_nxt_o = s;
  assign res0_o      = r0;
  assign res1_o      = r1;
  assign count_o     = n;

endmodule
